// ----- sv/okgh_pkg.sv -----
// Shared types and constants for the object key to group hash unit.
// Holds the FNV and finalizer constants and the controller/datapath structs.
// No dependencies.
package okgh_pkg;

  localparam int unsigned HashW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned BitIdxW = 6;
  localparam int unsigned GroupW = 16;
  localparam int unsigned ByteW = 8;

  localparam logic [HashW-1:0] FNV_BASIS = 64'd1469598103934665603;
  localparam logic [HashW-1:0] FMIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [HashW-1:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned FMIX_SHIFT = 33;
  localparam logic [1:0] LAST_ROUND = 2'd2;

  typedef enum logic [1:0] {
    MUL_LL,
    MUL_LH,
    MUL_HL
  } mul_sel_e;

  typedef struct packed {
    logic               fnv_part;
    logic               fnv_fold;
    logic               fin_load;
    logic               xs;
    logic               mul_go;
    mul_sel_e           mul_sel;
    logic               const_sel;
    logic               acc_load;
    logic               acc_add;
    logic               v_from_acc;
    logic               rem_clr;
    logic               div_step;
    logic [BitIdxW-1:0] div_idx;
    logic               out_load;
  } okgh_cmd_t;

  typedef struct packed {
    logic out_free;
  } okgh_sts_t;

endpackage

// ----- sv/okgh_in_if.sv -----
// Input channel of the hash unit: one key byte per beat with its flags.
// Depends on okgh_pkg.
interface okgh_in_if;
  logic                         valid;
  logic                         ready;
  logic [okgh_pkg::ByteW-1:0]   key_byte;
  logic                         byte_present;
  logic                         end_of_key;

  modport source (output valid, output key_byte, output byte_present, output end_of_key,
                  input ready);
  modport sink (input valid, input key_byte, input byte_present, input end_of_key,
                output ready);
endinterface

// ----- sv/okgh_out_if.sv -----
// Output channel of the hash unit: finalized hash and group index per beat.
// Depends on okgh_pkg.
interface okgh_out_if;
  logic                         valid;
  logic                         ready;
  logic [okgh_pkg::HashW-1:0]   key_hash;
  logic [okgh_pkg::GroupW-1:0]  group_index;

  modport source (output valid, output key_hash, output group_index, input ready);
  modport sink (input valid, input key_hash, input group_index, output ready);
endinterface

// ----- sv/okgh_ctrl.sv -----
// Sequencer of the hash unit: byte folding, finalizer steps, modulo loop.
// Depends on okgh_pkg; drives okgh_dp through okgh_cmd_t.
module okgh_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_present_i,
  input  logic               in_end_i,
  output logic               in_ready_o,
  input  okgh_pkg::okgh_sts_t sts_i,
  output okgh_pkg::okgh_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FNV  = 4'd1;
  localparam logic [3:0] S_XS   = 4'd2;
  localparam logic [3:0] S_MUL0 = 4'd3;
  localparam logic [3:0] S_MUL1 = 4'd4;
  localparam logic [3:0] S_MUL2 = 4'd5;
  localparam logic [3:0] S_MUL3 = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]                   state_q, state_d;
  logic [1:0]                   round_q, round_d;
  logic [okgh_pkg::BitIdxW-1:0] cnt_q, cnt_d;
  logic                         end_q, end_d;

  always_comb begin
    state_d    = state_q;
    round_d    = round_q;
    cnt_d      = cnt_q;
    end_d      = end_q;
    cmd_o      = '0;
    cmd_o.mul_sel   = okgh_pkg::MUL_LL;
    cmd_o.const_sel = round_q[0];
    cmd_o.div_idx   = ~cnt_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_present_i) begin
            cmd_o.fnv_part = 1'b1;
            end_d          = in_end_i;
            state_d        = S_FNV;
          end else if (in_end_i) begin
            cmd_o.fin_load = 1'b1;
            round_d        = '0;
            state_d        = S_XS;
          end
        end
      end
      S_FNV: begin
        cmd_o.fnv_fold = 1'b1;
        if (end_q) begin
          cmd_o.fin_load = 1'b1;
          round_d        = '0;
          state_d        = S_XS;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_XS: begin
        cmd_o.xs = 1'b1;
        if (round_q == okgh_pkg::LAST_ROUND) begin
          cmd_o.rem_clr = 1'b1;
          cnt_d         = '0;
          state_d       = S_DIV;
        end else begin
          state_d = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = okgh_pkg::MUL_LL;
        state_d       = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.acc_load = 1'b1;
        cmd_o.mul_go   = 1'b1;
        cmd_o.mul_sel  = okgh_pkg::MUL_LH;
        state_d        = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.acc_add = 1'b1;
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = okgh_pkg::MUL_HL;
        state_d       = S_MUL3;
      end
      S_MUL3: begin
        cmd_o.v_from_acc = 1'b1;
        round_d          = round_q + 2'd1;
        state_d          = S_XS;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      round_q <= '0;
      cnt_q   <= '0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      cnt_q   <= cnt_d;
      end_q   <= end_d;
    end
  end

endmodule

// ----- sv/okgh_dp.sv -----
// Datapath of the hash unit: FNV-1a state, shared 32x32 multiplier,
// xor-shift, bit-serial modulo and output register. Depends on okgh_pkg.
module okgh_dp #(
  parameter int unsigned GROUP_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [okgh_pkg::GroupW-1:0] cfg_data_i,
  input  logic [okgh_pkg::ByteW-1:0]  key_byte_i,
  input  okgh_pkg::okgh_cmd_t         cmd_i,
  output okgh_pkg::okgh_sts_t         sts_o,
  okgh_out_if.source                  out_ch_o
);

  localparam int unsigned HW = okgh_pkg::HashW;
  localparam int unsigned LW = okgh_pkg::HalfW;

  logic [GROUP_BITS-1:0] count_q;
  logic [HW-1:0]         hash_q, hash_d;
  logic [HW-1:0]         part_a_q, part_b_q;
  logic [HW-1:0]         v_q, acc_q, prod_q;
  logic [GROUP_BITS-1:0] rem_q, rem_d;
  logic [GROUP_BITS:0]   rem_sh;
  logic                  out_valid_q;
  logic [HW-1:0]         out_hash_q;
  logic [okgh_pkg::GroupW-1:0] out_idx_q;
  logic [HW-1:0]         x;
  logic [HW-1:0]         cst;
  logic [LW-1:0]         opa, opb;
  logic [LW-1:0]         acc_hi_sum;

  assign x = hash_q ^ {{(HW-okgh_pkg::ByteW){1'b0}}, key_byte_i};
  assign hash_d = cmd_i.fnv_fold ? (part_a_q + part_b_q) : hash_q;

  assign cst = cmd_i.const_sel ? okgh_pkg::FMIX_C2 : okgh_pkg::FMIX_C1;

  always_comb begin
    case (cmd_i.mul_sel)
      okgh_pkg::MUL_LL: begin
        opa = v_q[LW-1:0];
        opb = cst[LW-1:0];
      end
      okgh_pkg::MUL_LH: begin
        opa = v_q[LW-1:0];
        opb = cst[HW-1:LW];
      end
      okgh_pkg::MUL_HL: begin
        opa = v_q[HW-1:LW];
        opb = cst[LW-1:0];
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign acc_hi_sum = acc_q[HW-1:LW] + prod_q[LW-1:0];

  assign rem_sh = {rem_q, v_q[cmd_i.div_idx]};
  assign rem_d = (rem_sh >= {1'b0, count_q}) ? GROUP_BITS'(rem_sh - {1'b0, count_q})
                                             : rem_sh[GROUP_BITS-1:0];

  assign sts_o.out_free = !out_valid_q || out_ch_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= GROUP_BITS'(1);
      hash_q      <= okgh_pkg::FNV_BASIS;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= GROUP_BITS'(cfg_data_i);
      end
      if (cmd_i.fin_load) begin
        hash_q <= okgh_pkg::FNV_BASIS;
      end else begin
        hash_q <= hash_d;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fnv_part) begin
      part_a_q <= (x << 40) + (x << 8) + (x << 7);
      part_b_q <= (x << 5) + (x << 4) + (x << 1) + x;
    end
    if (cmd_i.fin_load) begin
      v_q <= hash_d;
    end else if (cmd_i.xs) begin
      v_q <= v_q ^ (v_q >> okgh_pkg::FMIX_SHIFT);
    end else if (cmd_i.v_from_acc) begin
      v_q <= {acc_hi_sum, acc_q[LW-1:0]};
    end
    if (cmd_i.mul_go) begin
      prod_q <= opa * opb;
    end
    if (cmd_i.acc_load) begin
      acc_q <= prod_q;
    end else if (cmd_i.acc_add) begin
      acc_q <= {acc_hi_sum, acc_q[LW-1:0]};
    end
    if (cmd_i.rem_clr) begin
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
    end
    if (cmd_i.out_load) begin
      out_hash_q <= v_q;
      out_idx_q  <= (count_q == '0) ? '0 : okgh_pkg::GroupW'(rem_q);
    end
  end

  assign out_ch_o.valid       = out_valid_q;
  assign out_ch_o.key_hash    = out_hash_q;
  assign out_ch_o.group_index = out_idx_q;

endmodule

// ----- sv/object_key_to_group_hash_unit.sv -----
// Sequence: each key byte is folded into the FNV state before the next is accepted;
// the end beat runs the finalizer (three xor-shifts, two multiplies of four steps
// on one shared 32x32 multiplier), then a bit-serial modulo over all 64 hash bits.
// No beat is accepted during a fold, the finalizer, the modulo or a pending load.
// The output register lets the next key start while a result waits.
// Reset: asynchronous, active low; hash returns to the FNV basis, group count to 1.
module object_key_to_group_hash_unit #(
  parameter int unsigned GROUP_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [okgh_pkg::GroupW-1:0] cfg_data_i,
  okgh_in_if.sink                     in_ch_i,
  okgh_out_if.source                  out_ch_o
);

  okgh_pkg::okgh_cmd_t cmd;
  okgh_pkg::okgh_sts_t sts;

  okgh_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch_i.valid),
    .in_present_i (in_ch_i.byte_present),
    .in_end_i     (in_ch_i.end_of_key),
    .in_ready_o   (in_ch_i.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  okgh_dp #(
    .GROUP_BITS (GROUP_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .key_byte_i (in_ch_i.key_byte),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_ch_o   (out_ch_o)
  );

endmodule

// ----- sv/okgh_checker.sv -----
// Port-level checks of the hash unit, bound to the top level.
// Depends on okgh_pkg and object_key_to_group_hash_unit.
module okgh_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        in_present_i,
  input logic                        in_end_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [okgh_pkg::HashW-1:0]  out_hash_i,
  input logic [okgh_pkg::GroupW-1:0] out_idx_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_hash_i) && $stable(out_idx_i))
    else $error("result payload changed while stalled");

  a_fold_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_present_i |=> !in_ready_i)
    else $error("byte beat accepted during fold cycle");

  a_fin_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_end_i |=> !$rose(out_valid_i))
    else $error("result appeared before finalize completed");

  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_end_i |=> ##1 !in_ready_i)
    else $error("input accepted during finalize");

endmodule

bind object_key_to_group_hash_unit okgh_checker u_okgh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch_i.valid),
  .in_ready_i   (in_ch_i.ready),
  .in_present_i (in_ch_i.byte_present),
  .in_end_i     (in_ch_i.end_of_key),
  .out_valid_i  (out_ch_o.valid),
  .out_ready_i  (out_ch_o.ready),
  .out_hash_i   (out_ch_o.key_hash),
  .out_idx_i    (out_ch_o.group_index)
);
